### hw/rtl/gal_pkg.sv
// Package: word types, unit command and operation codes for the gcd/lcm block
`default_nettype none
package gal_pkg;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned GCD_W = 32;
  localparam int unsigned LCM_W = 64;

  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic [IN_W-1:0] first_operand;
    logic [IN_W-1:0] second_operand;
  } gal_in_t;

  typedef struct packed {
    logic [GCD_W-1:0] divisor_result;
    logic [LCM_W-1:0] multiple_result;
    logic             both_zero_error;
  } gal_out_t;

  typedef struct packed {
    logic start;
    logic op;
  } gal_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/gal_unit.sv
// Shared bit-serial divide / shift-add multiply unit on one adder
`default_nettype none
module gal_unit #(
  parameter int unsigned W = 32
) (
  input  wire                logic            clk,
  input  wire                logic            rst_n,
  input  wire                gal_pkg::gal_cmd_t cmd,
  input  wire                logic [W-1:0]    opa,
  input  wire                logic [W-1:0]    opb,
  output logic                                done,
  output logic [W-1:0]                        quo,
  output logic [W-1:0]                        rem,
  output logic [2*W-1:0]                      prod
);
  import gal_pkg::*;

  localparam int unsigned CNT_W = $clog2(W);

  logic [W:0]       hi_r, hi_nxt;
  logic [W-1:0]     lo_r, lo_nxt;
  logic [W-1:0]     b_r;
  logic             op_r;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [W:0]       rem_sh;
  logic [W:0]       add_x, add_y;
  logic             add_c;
  logic [W+1:0]     add_s;

  always_comb begin
    rem_sh = {hi_r[W-1:0], lo_r[W-1]};
    if (op_r == OP_DIV) begin
      add_x = rem_sh;
      add_y = ~{1'b0, b_r};
      add_c = 1'b1;
    end else begin
      add_x = hi_r;
      add_y = lo_r[0] ? {1'b0, b_r} : '0;
      add_c = 1'b0;
    end
    add_s = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_c};
  end

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      hi_nxt   = '0;
      lo_nxt   = opa;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (op_r == OP_DIV) begin
        // carry out set when the shifted remainder is not below the divisor
        if (add_s[W+1]) begin
          hi_nxt = add_s[W:0];
          lo_nxt = {lo_r[W-2:0], 1'b1};
        end else begin
          hi_nxt = rem_sh;
          lo_nxt = {lo_r[W-2:0], 1'b0};
        end
      end else begin
        hi_nxt = {1'b0, add_s[W:1]};
        lo_nxt = {add_s[0], lo_r[W-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (cmd.start) begin
      b_r  <= opb;
      op_r <= cmd.op;
    end
  end

  assign done = done_r;
  assign quo  = lo_r;
  assign rem  = hi_r[W-1:0];
  assign prod = {hi_r[W-1:0], lo_r};

endmodule
`default_nettype wire

### hw/rtl/gcd_and_lcm.sv
// Top level: gcd by Euclid's remainder method and lcm as (a / gcd) * b
// Each remainder step, the quotient a / gcd and the product run in turn on the one shared
// divide/multiply unit; a word with both operands zero skips the unit and flags both_zero_error.
// One word in flight; in_stall is high until the result is registered, then the next word can be taken.
// Synchronous active-low reset clears the sequencer and drops any pending result.
`default_nettype none
module gcd_and_lcm #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire  logic              clk,
  input  wire  logic              rst_n,
  input  wire  logic              in_valid,
  output logic                    in_stall,
  input  wire  gal_pkg::gal_in_t  in_data,
  output logic                    out_valid,
  input  wire  logic              out_stall,
  output gal_pkg::gal_out_t       out_data
);
  import gal_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_QUO  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]   state_r, state_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [W-1:0] big_r, big_nxt;
  logic [W-1:0] small_r, small_nxt;
  gal_out_t     res_r, res_nxt;
  gal_out_t     out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [W-1:0] in_a, in_b;
  logic         accept;

  gal_cmd_t     cmd;
  logic [W-1:0] opa, opb;
  logic         u_done;
  logic [W-1:0] u_quo, u_rem;
  logic [2*W-1:0] u_prod;

  gal_unit #(.W(W)) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .opa  (opa),
    .opb  (opb),
    .done (u_done),
    .quo  (u_quo),
    .rem  (u_rem),
    .prod (u_prod)
  );

  assign in_a   = in_data.first_operand[W-1:0];
  assign in_b   = in_data.second_operand[W-1:0];
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    big_nxt       = big_r;
    small_nxt     = small_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{start: 1'b0, op: OP_DIV};
    opa           = big_r;
    opb           = small_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt = in_a;
          b_nxt = in_b;
          if (in_b > in_a) begin
            big_nxt   = in_b;
            small_nxt = in_a;
          end else begin
            big_nxt   = in_a;
            small_nxt = in_b;
          end
          if (in_a == '0 && in_b == '0) begin
            res_nxt   = '{divisor_result: '0, multiple_result: '0, both_zero_error: 1'b1};
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd.start = 1'b1;
        if (small_r == '0) begin
          opa       = a_r;
          opb       = big_r;
          state_nxt = S_QUO;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (u_done) begin
          big_nxt   = small_r;
          small_nxt = u_rem;
          state_nxt = S_STEP;
        end
      end
      S_QUO: begin
        opa = u_quo;
        opb = b_r;
        if (u_done) begin
          cmd       = '{start: 1'b1, op: OP_MUL};
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (u_done) begin
          res_nxt.divisor_result  = GCD_W'(big_r);
          res_nxt.multiple_result = LCM_W'(u_prod);
          res_nxt.both_zero_error = 1'b0;
          state_nxt               = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    big_r   <= big_nxt;
    small_r <= small_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### tb/gcd_and_lcm_test.sv
// Testbench for gcd_and_lcm: bursty driver, stalling receiver and gcd/lcm scoreboard
`timescale 1ns / 1ps
module gcd_and_lcm_test;
  import gal_pkg::*;

  localparam int unsigned OPW            = 32;
  localparam int unsigned RANDOM_WORDS   = 1300;
  localparam int unsigned DRAIN_EVERY    = 300;
  localparam int unsigned SETTLE_CYCLES  = 2000;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    gal_in_t word;
    bit      drain;
  } pending_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BEAT, RX_CHOKED} rx_mode_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  gal_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gal_out_t out_data;

  pending_t    pending_words[$];
  gal_out_t    awaited_results[$];
  int unsigned in_flight;
  int unsigned gap_left;
  int unsigned burst_left;
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  logic [7:0]  rx_tick;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned words_accepted;
  int unsigned results_checked;
  int unsigned both_zero_seen;
  int unsigned directed_words;

  gcd_and_lcm #(.OPERAND_WIDTH(OPW)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic gal_out_t gcd_lcm_of(gal_in_t w);
    logic [63:0]     msk;
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    logic [IN_W-1:0] hi;
    logic [IN_W-1:0] lo;
    logic [IN_W-1:0] r;
    gal_out_t        res;
    msk = (64'd1 << OPW) - 64'd1;
    a   = w.first_operand & msk[IN_W-1:0];
    b   = w.second_operand & msk[IN_W-1:0];
    res = '0;
    if (a == '0 && b == '0) begin
      res.both_zero_error = 1'b1;
      return res;
    end
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    while (lo != '0) begin
      r  = hi % lo;
      hi = lo;
      lo = r;
    end
    res.divisor_result  = hi;
    res.multiple_result = LCM_W'(a / hi) * LCM_W'(b);
    return res;
  endfunction

  function automatic logic [31:0] rand_bits(int unsigned width);
    logic [63:0] msk;
    msk = (64'd1 << width) - 64'd1;
    return $urandom() & msk[31:0];
  endfunction

  // consecutive Fibonacci numbers: the longest remainder chains
  function automatic gal_in_t fib_pair(int unsigned n);
    logic [31:0] f0;
    logic [31:0] f1;
    logic [31:0] t;
    gal_in_t     w;
    f0 = 32'd0;
    f1 = 32'd1;
    for (int unsigned i = 1; i < n; i++) begin
      t  = f0 + f1;
      f0 = f1;
      f1 = t;
    end
    w.first_operand  = f1;
    w.second_operand = f0;
    return w;
  endfunction

  function automatic gal_in_t random_word();
    gal_in_t     w;
    logic [31:0] g;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
    int unsigned wg;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        w.first_operand  = rand_bits($urandom_range(1, 32));
        w.second_operand = rand_bits($urandom_range(1, 32));
      end
      3, 4: begin
        wg = $urandom_range(1, 16);
        g  = rand_bits(wg);
        x  = rand_bits($urandom_range(0, 32 - wg));
        y  = rand_bits($urandom_range(0, 32 - wg));
        w.first_operand  = g * x;
        w.second_operand = g * y;
      end
      5: begin
        w.first_operand  = rand_bits($urandom_range(1, 32));
        w.second_operand = '0;
      end
      6: begin
        w.first_operand  = rand_bits($urandom_range(1, 32));
        w.second_operand = w.first_operand;
      end
      7: w = fib_pair($urandom_range(2, 47));
      8: begin
        x = rand_bits($urandom_range(1, 16));
        y = rand_bits($urandom_range(0, 16));
        w.first_operand  = x;
        w.second_operand = x * y;
      end
      9, 10: begin
        w.first_operand  = $urandom();
        w.second_operand = $urandom();
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          w = '0;
        end else begin
          w.first_operand  = 32'd1 << $urandom_range(0, 31);
          w.second_operand = 32'd1 << $urandom_range(0, 31);
        end
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      t                = w.first_operand;
      w.first_operand  = w.second_operand;
      w.second_operand = t;
    end
    return w;
  endfunction

  task automatic queue_word(input logic [31:0] a, input logic [31:0] b, input bit drain);
    pending_t p;
    p.word.first_operand  = a;
    p.word.second_operand = b;
    p.drain               = drain;
    pending_words.push_back(p);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      9:             return $urandom_range(20, 400);
      default:       return $urandom_range(1, 12);
    endcase
  endfunction

  // sender: bursts of words with gaps; a drain word waits for every result
  always @(posedge clk) begin : drive
    int unsigned flight_now;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      in_flight  <= 0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      flight_now = in_flight + ((in_valid && !in_stall) ? 1 : 0)
                   - ((out_valid && !out_stall) ? 1 : 0);
      in_flight <= flight_now;
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && flight_now != 0)) begin
          in_data  <= pending_words[0].word;
          in_valid <= 1'b1;
          void'(pending_words.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= pick_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches among open, random, beat and choked modes
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      rx_mode      <= RX_OPEN;
      rx_mode_left <= 0;
      rx_tick      <= '0;
    end else begin
      rx_tick <= rx_tick + 8'd1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(100, 2000);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        RX_BEAT:   out_stall <= rx_tick[4];
        default:   out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check
    gal_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(gcd_lcm_of(in_data));
        words_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing awaited: %h", out_data));
        end else begin
          want = awaited_results.pop_front();
          if (out_data.divisor_result !== want.divisor_result)
            report_mismatch($sformatf("result %0d divisor_result: got %h, expected %h",
                                      results_checked, out_data.divisor_result,
                                      want.divisor_result));
          if (out_data.multiple_result !== want.multiple_result)
            report_mismatch($sformatf("result %0d multiple_result: got %h, expected %h",
                                      results_checked, out_data.multiple_result,
                                      want.multiple_result));
          if (out_data.both_zero_error !== want.both_zero_error)
            report_mismatch($sformatf("result %0d both_zero_error: got %b, expected %b",
                                      results_checked, out_data.both_zero_error,
                                      want.both_zero_error));
          if (want.both_zero_error)
            both_zero_seen++;
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("gcd_and_lcm test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    gal_in_t w;
    queue_word(32'd0, 32'd0, 1'b0);
    queue_word(32'd0, 32'd1, 1'b0);
    queue_word(32'd1, 32'd0, 1'b0);
    queue_word(32'd0, 32'hFFFF_FFFF, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'd0, 1'b0);
    queue_word(32'd1, 32'd1, 1'b0);
    queue_word(32'd1, 32'hFFFF_FFFF, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    queue_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
    queue_word(32'hFFFF_FFFB, 32'hFFFF_FFEF, 1'b0);
    queue_word(32'd12, 32'd18, 1'b0);
    queue_word(32'd18, 32'd12, 1'b0);
    queue_word(32'd7, 32'd7, 1'b0);
    queue_word(32'h8000_0000, 32'h4000_0000, 1'b0);
    queue_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    w = fib_pair(47);
    queue_word(w.first_operand, w.second_operand, 1'b0);
    queue_word(w.second_operand, w.first_operand, 1'b0);
    queue_word(32'd0, 32'd0, 1'b0);
    directed_words = pending_words.size();
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      w = random_word();
      queue_word(w.first_operand, w.second_operand, (n % DRAIN_EVERY) == 0);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d words (%0d directed, rest random), %0d results checked",
             words_accepted, directed_words, results_checked);
    $display("both-zero words seen: %0d, mismatches: %0d", both_zero_seen, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("gcd_and_lcm test passed");
    end else begin
      $display("gcd_and_lcm test failed");
    end
    $finish;
  end

endmodule
